// ----- sv/npnp_pkg.sv -----
// npnp_pkg: shared types and constants for the nearest palette nibble packer.
// No dependencies.
package npnp_pkg;

    localparam int REG_COUNT   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int SQ_W        = 2 * CHAN_W;
    localparam int DIST_W      = SQ_W + 2;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [COLOR_W-1:0]   color_t;
    typedef logic [DIST_W-1:0]    dist_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [QLVL_W-1:0]    qlvl_t;

    // Distance given to entries outside the searched range; above any real distance.
    localparam dist_t DIST_NONE = '1;

    localparam color_t RESET_PALETTE [REG_COUNT] = '{
        24'h000000, 24'hFFFFFF, 24'h438A1C, 24'h6440FF,
        24'hBF0000, 24'hFFF338, 24'hE87E00, 24'hC2A4F4
    };

    // Index item moving from the front pipeline into the queue.
    typedef struct packed {
        logic valid;
        idx_t idx;
    } idx_push_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic avail;
        idx_t idx;
    } idx_head_t;

endpackage

// ----- sv/npnp_front.sv -----
// npnp_front: palette registers, distance stage and argmin stage.
// Depends on npnp_pkg.
module npnp_front
    import npnp_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  color_t    cfg_data,
    input  logic      accept,
    input  chan_t     red,
    input  chan_t     green,
    input  chan_t     blue,
    output logic      busy_s1,
    output idx_push_t push_out
);

    color_t color_reg [REG_COUNT];
    dist_t  dist_reg  [REG_COUNT];
    dist_t  dist_next [REG_COUNT];
    logic   s1_valid_reg;
    logic   s2_valid_reg;
    idx_t   s2_idx_reg;
    idx_t   s2_idx_next;

    dist_t  l1_d [4];
    idx_t   l1_i [4];
    dist_t  l2_d [2];
    idx_t   l2_i [2];

    function automatic logic [SQ_W-1:0] sq_diff(input chan_t a, input chan_t b);
        chan_t d;
        d = (a > b) ? (a - b) : (b - a);
        return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                color_reg[i] <= RESET_PALETTE[i];
            end
        end
        else
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                if (cfg_we && (cfg_index == CFG_IDX_W'(i)))
                begin
                    color_reg[i] <= cfg_data;
                end
            end
        end
    end

    generate
        for (genvar p = 0; p < REG_COUNT; p++)
        begin : g_dist
            if (p < PALETTE_ENTRIES)
            begin : g_used
                always_comb
                begin
                    dist_next[p] = {2'b00, sq_diff(red,   color_reg[p][23:16])}
                                 + {2'b00, sq_diff(green, color_reg[p][15:8])}
                                 + {2'b00, sq_diff(blue,  color_reg[p][7:0])};
                end
            end
            else
            begin : g_unused
                assign dist_next[p] = DIST_NONE;
            end
        end
    endgenerate

    // Ties keep the lower index.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dist_reg[2*i+1] < dist_reg[2*i])
            begin
                l1_d[i] = dist_reg[2*i+1];
                l1_i[i] = IDX_W'(2*i+1);
            end
            else
            begin
                l1_d[i] = dist_reg[2*i];
                l1_i[i] = IDX_W'(2*i);
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (l1_d[2*i+1] < l1_d[2*i])
            begin
                l2_d[i] = l1_d[2*i+1];
                l2_i[i] = l1_i[2*i+1];
            end
            else
            begin
                l2_d[i] = l1_d[2*i];
                l2_i[i] = l1_i[2*i];
            end
        end
        s2_idx_next = (l2_d[1] < l2_d[0]) ? l2_i[1] : l2_i[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                dist_reg[i] <= dist_next[i];
            end
        end
        if (s1_valid_reg)
        begin
            s2_idx_reg <= s2_idx_next;
        end
    end

    assign busy_s1        = s1_valid_reg;
    assign push_out.valid = s2_valid_reg;
    assign push_out.idx   = s2_idx_reg;

endmodule

// ----- sv/npnp_queue.sv -----
// npnp_queue: short index queue between the front pipeline and the back end.
// Depends on npnp_pkg.
module npnp_queue
    import npnp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  idx_push_t push_in,
    input  logic      take,
    output idx_head_t head,
    output qlvl_t     level
);

    idx_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    qlvl_t              level_reg;
    qlvl_t              level_next;
    logic               do_pop;

    assign do_pop = take && (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = push_in.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push_in.valid && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!push_in.valid && do_pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.valid)
        begin
            slot_reg[wr_ptr_reg] <= push_in.idx;
        end
    end

    assign head.avail = (level_reg != '0);
    assign head.idx   = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

endmodule

// ----- sv/npnp_back.sv -----
// npnp_back: pairs indices and packs two of them into one output byte.
// Depends on npnp_pkg.
module npnp_back
    import npnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  idx_head_t   head,
    output logic        take,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  packed_pair
);

    logic       second_phase_reg;
    logic       second_phase_next;
    idx_t       held_index_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic       pop_eff;

    assign pop_eff = pop && out_valid_reg;
    assign take    = head.avail && (!second_phase_reg || !out_valid_reg || pop);

    always_comb
    begin
        second_phase_next = second_phase_reg;
        out_valid_next    = out_valid_reg && !pop_eff;
        if (take)
        begin
            second_phase_next = !second_phase_reg;
            if (second_phase_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_phase_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            held_index_reg   <= '0;
        end
        else
        begin
            second_phase_reg <= second_phase_next;
            out_valid_reg    <= out_valid_next;
            if (take && !second_phase_reg)
            begin
                held_index_reg <= head.idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && second_phase_reg)
        begin
            out_data_reg <= {1'b0, held_index_reg, 1'b0, head.idx};
        end
    end

    assign empty       = !out_valid_reg;
    assign packed_pair = out_data_reg;

endmodule

// ----- sv/nearest_palette_nibble_packer_top.sv -----
// nearest_palette_nibble_packer_top: nearest palette match, two indices per byte.
// Depends on npnp_pkg, npnp_front, npnp_queue, npnp_back.
//
//   channel   signals                      width   direction
//   pixel     push, full, red/green/blue   8 each  in
//   result    empty, pop, packed_pair      8       out
//   config    cfg_we, cfg_index, cfg_data  3/24    in
//
// One pixel per clock while full is low; a byte reaches the result ports after the
// second pixel of its pair passes the argmin stage, queue and output register.
// full is a credit check: queue level plus the two pipeline stages.
// Reset loads the default palette and starts with the first pixel of a pair.
// A stalled pop backs the queue up and raises full once four indices wait
// in the pipeline and queue.
module nearest_palette_nibble_packer_top
    import npnp_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CHAN_W-1:0]    red,
    input  logic [CHAN_W-1:0]    green,
    input  logic [CHAN_W-1:0]    blue,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           packed_pair,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    logic      accept;
    logic      busy_s1;
    idx_push_t push_bus;
    idx_head_t head_bus;
    qlvl_t     level;
    logic      take;
    qlvl_t     pending;

    assign pending = level + QLVL_W'(busy_s1) + QLVL_W'(push_bus.valid);
    assign full    = (pending >= QLVL_W'(QUEUE_DEPTH));
    assign accept  = push && !full;

    npnp_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .busy_s1   (busy_s1),
        .push_out  (push_bus)
    );

    npnp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push_bus),
        .take    (take),
        .head    (head_bus),
        .level   (level)
    );

    npnp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_bus),
        .take        (take),
        .pop         (pop),
        .empty       (empty),
        .packed_pair (packed_pair)
    );

endmodule
